// File: sv/segt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segt_pkg: shared types and constants of the range-sum tree
// Field widths of the item and result beats, opcode values and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package segt_pkg;

  // Field widths
  localparam int OpW   = 1;
  localparam int PosW  = 10;
  localparam int DataW = 32;
  localparam int SizeW = 11;

  // Opcodes
  localparam logic [OpW-1:0] OP_UPDATE = 1'b0;
  localparam logic [OpW-1:0] OP_QUERY  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_DONE
  } state_e;

endpackage

// File: sv/segt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segt_in_if: item channel of the range-sum tree
// Valid/ready channel carrying one update or query beat.
// ----------------------------------------------------------------------------
interface segt_in_if import segt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          op;
  logic [PosW-1:0]         position;
  logic [PosW-1:0]         right_bound;
  logic signed [DataW-1:0] new_value;

  modport source (output valid, op, position, right_bound, new_value, input ready);
  modport sink   (input valid, op, position, right_bound, new_value, output ready);
endinterface

// File: sv/segt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segt_out_if: result channel of the range-sum tree
// Valid/ready channel carrying one result beat per item.
// ----------------------------------------------------------------------------
interface segt_out_if import segt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] range_sum;
  logic                    bad_index;

  modport source (output valid, range_sum, bad_index, input ready);
  modport sink   (input valid, range_sum, bad_index, output ready);
endinterface

// File: sv/segment_tree_range_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum: point update / inclusive range sum over a tree
// Usage:
//   in_i carries one beat per item: op selects update (write new_value at
//   position) or query (wrapped sum of elements position..right_bound).
//   out_o returns exactly one beat per item: range_sum (0 for updates and
//   empty ranges) and bad_index when an index is at or beyond the size in use.
//   cfg_we_i/cfg_wdata_i write size_in_use; a write also clears all sums.
// Structure:
//   Sums live in a 2*MAX_ELEMENTS word memory with one write and two read
//   ports, walked one tree level per cycle by the update and query adders.
//   An update walks from the leaf up to the root; a query walks up until its
//   borders meet; a bad index or empty range goes straight to the result.
//   in_i.ready is high only while the sequencer is idle.
// Reset and stalls:
//   After reset, and after every size write, a clearing pass zeroes the memory
//   one word per cycle, with in_i.ready low until it ends.
//   The result sits in an output register; a new item is taken while it waits,
//   and the next result is held back until the register frees.
// ----------------------------------------------------------------------------
module segment_tree_range_sum import segt_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  segt_in_if.sink          in_i,
  segt_out_if.source       out_o
);

  // Node address width: leaves at MAX_ELEMENTS+i, root at 1
  localparam int AW    = $clog2(2 * MAX_ELEMENTS);
  localparam int Depth = 2 * MAX_ELEMENTS;
  localparam int LW    = AW + PosW + 1;
  localparam int NB    = $clog2(MAX_ELEMENTS + 1);
  localparam int NW    = (NB > SizeW) ? NB : SizeW;
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);
  localparam logic [AW-1:0] RootAddr = AW'(1);

  // Sum memory
  logic [DataW-1:0] mem [Depth];
  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd0_addr, rd1_addr;
  logic [DataW-1:0] wr_data, rd0_q, rd1_q;

  // Sequencer state
  state_e           state_q, state_d;
  logic [SizeW-1:0] size_q;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    l_q, l_d;
  logic [AW:0]      r_q, r_d;
  logic             fl_q, fl_d, fr_q, fr_d;
  logic [DataW-1:0] cur_q, cur_d, acc_q, acc_d;
  logic [DataW-1:0] res_sum_q, res_sum_d;
  logic             res_bad_q, res_bad_d;
  logic             out_valid_q, out_load;
  logic [DataW-1:0] out_sum_q;
  logic             out_bad_q;

  // Item decode
  logic             in_fire;
  logic [NW-1:0]    size_ext, max_n, live_n, pos_ext, rb_ext;
  logic             pos_bad, rb_bad, item_bad;
  logic [LW-1:0]    leaf_w, r_init_w;
  logic [AW-1:0]    leaf;
  logic [AW-1:0]    parent;
  logic [DataW-1:0] upd_sum, acc_sum;
  logic [AW:0]      l_next_w, r_m1;
  logic             l_lt_r;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;

  // Live size: zero acts as one, clamp at the tree capacity
  assign size_ext = NW'(size_q);
  assign max_n    = NW'(MAX_ELEMENTS);
  always_comb begin
    if (size_ext == '0) begin
      live_n = NW'(1);
    end else if (size_ext > max_n) begin
      live_n = max_n;
    end else begin
      live_n = size_ext;
    end
  end

  assign pos_ext  = NW'(in_i.position);
  assign rb_ext   = NW'(in_i.right_bound);
  assign pos_bad  = (pos_ext >= live_n);
  assign rb_bad   = (rb_ext >= live_n);
  assign item_bad = pos_bad | ((in_i.op == OP_QUERY) & rb_bad);

  // Leaf address and exclusive right end of a query
  assign leaf_w   = LW'(MAX_ELEMENTS) + LW'(in_i.position);
  assign leaf     = leaf_w[AW-1:0];
  assign r_init_w = LW'(MAX_ELEMENTS) + LW'(in_i.right_bound) + LW'(1);

  // Walk helpers
  assign parent   = idx_q >> 1;
  assign upd_sum  = cur_q + rd0_q;
  assign acc_sum  = acc_q + (fl_q ? rd0_q : '0) + (fr_q ? rd1_q : '0);
  assign l_next_w = {1'b0, l_q} + {{AW{1'b0}}, l_q[0]};
  assign r_m1     = r_q - (AW+1)'(1);
  assign l_lt_r   = ({1'b0, l_q} < r_q);

  // Next state and datapath control
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    idx_d     = idx_q;
    l_d       = l_q;
    r_d       = r_q;
    fl_d      = 1'b0;
    fr_d      = 1'b0;
    cur_d     = cur_q;
    acc_d     = acc_q;
    res_sum_d = res_sum_q;
    res_bad_d = res_bad_q;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd0_addr  = '0;
    rd1_addr  = '0;
    out_load  = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // sibling of the leaf, used by the first update level
        rd0_addr = leaf ^ AW'(1);
        if (in_fire) begin
          if (item_bad) begin
            res_sum_d = '0;
            res_bad_d = 1'b1;
            state_d   = ST_DONE;
          end else if (in_i.op == OP_UPDATE) begin
            wr_en   = 1'b1;
            wr_addr = leaf;
            wr_data = in_i.new_value;
            cur_d   = in_i.new_value;
            idx_d   = leaf;
            state_d = ST_UPD;
          end else if (in_i.position > in_i.right_bound) begin
            // empty range
            res_sum_d = '0;
            res_bad_d = 1'b0;
            state_d   = ST_DONE;
          end else begin
            l_d     = leaf;
            r_d     = r_init_w[AW:0];
            acc_d   = '0;
            state_d = ST_QRY;
          end
        end
      end
      ST_UPD: begin
        // parent = running sum + sibling read last cycle
        wr_en    = 1'b1;
        wr_addr  = parent;
        wr_data  = upd_sum;
        cur_d    = upd_sum;
        idx_d    = parent;
        rd0_addr = parent ^ AW'(1);
        if (parent == RootAddr) begin
          res_sum_d = '0;
          res_bad_d = 1'b0;
          state_d   = ST_DONE;
        end
      end
      ST_QRY: begin
        // fold in last level's nodes, fetch this level's border nodes
        acc_d = acc_sum;
        if (l_lt_r) begin
          rd0_addr = l_q;
          rd1_addr = r_m1[AW-1:0];
          fl_d     = l_q[0];
          fr_d     = r_q[0];
          l_d      = l_next_w[AW:1];
          r_d      = r_q >> 1;
        end else begin
          res_sum_d = acc_sum;
          res_bad_d = 1'b0;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase

    // size write restarts the clearing pass
    if (cfg_we_i) begin
      state_d   = ST_CLEAR;
      clr_cnt_d = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      size_q      <= SizeW'(1024);
      fl_q        <= 1'b0;
      fr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      fl_q      <= fl_d;
      fr_q      <= fr_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk and result registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    l_q       <= l_d;
    r_q       <= r_d;
    cur_q     <= cur_d;
    acc_q     <= acc_d;
    res_sum_q <= res_sum_d;
    res_bad_q <= res_bad_d;
    if (out_load) begin
      out_sum_q <= res_sum_q;
      out_bad_q <= res_bad_q;
    end
  end

  // Sum memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0_q <= mem[rd0_addr];
    rd1_q <= mem[rd1_addr];
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.range_sum = $signed(out_sum_q);
  assign out_o.bad_index = out_bad_q;

endmodule
